// ===== sv/sus_pkg.sv =====
`default_nettype none

package sus_pkg;

  localparam int ID_W  = 16;
  localparam int CNT_W = 6;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_INSERTED  = 2'd0,
    STATUS_DUPLICATE = 2'd1,
    STATUS_DROPPED   = 2'd2
  } sus_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_READOUT
  } sus_state_t;

  typedef struct packed {
    logic [ID_W-1:0] group_id;
    logic            first;
    logic            last;
  } sus_in_t;

  typedef struct packed {
    logic             kind;
    sus_status_t      status;
    logic [ID_W-1:0]  value;
    logic [CNT_W-1:0] entry_count;
    logic             last_out;
  } sus_out_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic            ins;
    logic            rot;
    logic [ID_W-1:0] id;
  } sus_ctl_t;

endpackage

`default_nettype wire

// ===== sv/sorted_unique_id_set_merge.sv =====
// Sorted unique ID set. Each offered group ID is compared against every held
// entry at once by a chain of TABLE_DEPTH cells, and an insertion shifts the
// larger entries up one cell in the same cycle. After an item with last low
// the next may be accepted as soon as its status word can enter the output
// register. With last high and a non-empty set the block then reads the table
// out through the head cell, rotating the chain one place per word, and takes
// no new item until the last entry word has entered the output register; the
// rotation leaves the table in its original order. first empties the set
// before the item. capacity_limit above TABLE_DEPTH acts as TABLE_DEPTH, and a
// limit of zero drops every new ID.
`default_nettype none

module sorted_unique_id_set_merge #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire sus_pkg::sus_in_t           in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output sus_pkg::sus_out_t               out_data,
  input  wire logic                       cfg_we,
  input  wire logic [sus_pkg::CNT_W-1:0]  cfg_wdata
);

  localparam logic [sus_pkg::CNT_W-1:0] DEPTH_C = sus_pkg::CNT_W'(TABLE_DEPTH);

  logic [sus_pkg::CNT_W-1:0] capacity_limit;
  logic [sus_pkg::CNT_W-1:0] count;
  logic [sus_pkg::CNT_W-1:0] count_next;
  logic [sus_pkg::CNT_W-1:0] rem;
  logic [sus_pkg::CNT_W-1:0] eff_count;
  logic [sus_pkg::CNT_W-1:0] cap;
  sus_pkg::sus_state_t       state;
  sus_pkg::sus_state_t       state_next;
  sus_pkg::sus_ctl_t         ctl;
  sus_pkg::sus_status_t      status;

  logic [sus_pkg::ID_W-1:0] cell_data [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   occ;
  logic [TABLE_DEPTH-1:0]   tail;
  logic [TABLE_DEPTH-1:0]   le;
  logic [TABLE_DEPTH-1:0]   eq;

  logic out_free;
  logic accept;
  logic dup;
  logic full;
  logic load_entry;

  assign out_free  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign eff_count = in_data.first ? '0 : count;
  assign cap       = (capacity_limit > DEPTH_C) ? DEPTH_C : capacity_limit;
  assign dup       = |eq;
  assign full      = eff_count >= cap;

  always_comb begin
    if (dup) begin
      status = sus_pkg::STATUS_DUPLICATE;
    end else if (full) begin
      status = sus_pkg::STATUS_DROPPED;
    end else begin
      status = sus_pkg::STATUS_INSERTED;
    end
  end

  assign count_next = (status == sus_pkg::STATUS_INSERTED) ? eff_count + 1'b1 : eff_count;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign occ[i]  = sus_pkg::CNT_W'(i) < eff_count;
    assign tail[i] = (count != '0) && (sus_pkg::CNT_W'(i) == count - 1'b1);

    sus_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ[i]),
      .tail       (tail[i]),
      .left_le    ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i-1]),
      .left_data  (cell_data[(i == 0) ? 0 : i-1]),
      .right_data (cell_data[(i == TABLE_DEPTH-1) ? 0 : i+1]),
      .head_data  (cell_data[0]),
      .data       (cell_data[i]),
      .le         (le[i]),
      .eq         (eq[i])
    );
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sus_pkg::ST_IDLE: begin
        if (accept && in_data.last && (count_next != '0)) begin
          state_next = sus_pkg::ST_READOUT;
        end
      end
      sus_pkg::ST_READOUT: begin
        if (out_free && (rem == sus_pkg::CNT_W'(1))) begin
          state_next = sus_pkg::ST_IDLE;
        end
      end
      default: state_next = sus_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    in_ready   = 1'b0;
    load_entry = 1'b0;
    unique case (state)
      sus_pkg::ST_IDLE:    in_ready   = out_free && !rst;
      sus_pkg::ST_READOUT: load_entry = out_free;
      default: ;
    endcase
  end

  always_comb begin
    ctl.id  = in_data.group_id;
    ctl.ins = accept && (status == sus_pkg::STATUS_INSERTED);
    ctl.rot = load_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= sus_pkg::ST_IDLE;
      count          <= '0;
      rem            <= '0;
      out_valid      <= 1'b0;
      capacity_limit <= 6'd32;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity_limit <= cfg_wdata;
      end
      if (accept) begin
        count <= count_next;
        rem   <= count_next;
      end else if (load_entry) begin
        rem <= rem - 1'b1;
      end
      if (accept || load_entry) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.kind        <= sus_pkg::KIND_STATUS;
      out_data.status      <= status;
      out_data.value       <= in_data.group_id;
      out_data.entry_count <= count_next;
      out_data.last_out    <= !in_data.last || (count_next == '0);
    end else if (load_entry) begin
      out_data.kind        <= sus_pkg::KIND_ENTRY;
      out_data.status      <= sus_pkg::STATUS_INSERTED;
      out_data.value       <= cell_data[0];
      out_data.entry_count <= count;
      out_data.last_out    <= (rem == sus_pkg::CNT_W'(1));
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("held count exceeds table depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && !in_data.first && (status == sus_pkg::STATUS_INSERTED)
    |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the set by one");

  a_readout_rem: assert property (@(posedge clk) disable iff (rst)
    state == sus_pkg::ST_READOUT |-> (rem != '0) && (rem <= count))
    else $error("readout word counter out of range");

  a_no_accept_in_readout: assert property (@(posedge clk) disable iff (rst)
    state == sus_pkg::ST_READOUT |-> !in_ready)
    else $error("input accepted during readout");
`endif

endmodule

`default_nettype wire

// ===== sv/sus_cell.sv =====
`default_nettype none

module sus_cell (
  input  wire logic                      clk,
  input  wire sus_pkg::sus_ctl_t         ctl,
  input  wire logic                      occ,
  input  wire logic                      tail,
  input  wire logic                      left_le,
  input  wire logic [sus_pkg::ID_W-1:0]  left_data,
  input  wire logic [sus_pkg::ID_W-1:0]  right_data,
  input  wire logic [sus_pkg::ID_W-1:0]  head_data,
  output logic      [sus_pkg::ID_W-1:0]  data,
  output logic                           le,
  output logic                           eq
);

  logic [sus_pkg::ID_W-1:0] data_next;

  assign le = occ && (data < ctl.id);
  assign eq = occ && (data == ctl.id);

  // On insert, entries below the new ID stay, the first cell past them takes
  // the ID, and the rest move up by one. On readout the held entries rotate
  // down, the head wrapping around to the tail.
  always_comb begin
    data_next = data;
    if (ctl.ins) begin
      if (le) begin
        data_next = data;
      end else if (left_le) begin
        data_next = ctl.id;
      end else begin
        data_next = left_data;
      end
    end else if (ctl.rot) begin
      data_next = tail ? head_data : right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

// ===== tb/tb_sorted_unique_id_set_merge.sv =====
`default_nettype none

module tb_sorted_unique_id_set_merge;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;

  // Tracks the expected contents of the ID set and the words the block owes.
  class id_set_scoreboard;
    logic [sus_pkg::ID_W-1:0]  held_ids [DEPTH];
    int                        held;
    logic [sus_pkg::CNT_W-1:0] capacity;
    sus_pkg::sus_out_t         owed_words [$];
    int                        errors;
    int                        words_checked;
    int                        inserted;
    int                        duplicates;
    int                        dropped;

    function new();
      held = 0;
      capacity = sus_pkg::CNT_W'(32);
      errors = 0;
      words_checked = 0;
      inserted = 0;
      duplicates = 0;
      dropped = 0;
      foreach (held_ids[i]) held_ids[i] = '0;
    endfunction

    function void set_capacity(input logic [sus_pkg::CNT_W-1:0] limit);
      capacity = limit;
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    function void note_offer(input sus_pkg::sus_in_t offer);
      int                   room;
      int                   pos;
      bit                   found;
      sus_pkg::sus_status_t outcome;
      sus_pkg::sus_out_t    w;
      found = 0;
      if (offer.first) held = 0;
      room = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
      for (int i = 0; i < held; i++) begin
        if (held_ids[i] == offer.group_id) found = 1;
      end
      if (found) begin
        outcome = sus_pkg::STATUS_DUPLICATE;
        duplicates++;
      end else if (held >= room) begin
        outcome = sus_pkg::STATUS_DROPPED;
        dropped++;
      end else begin
        pos = held;
        while (pos > 0 && held_ids[pos-1] > offer.group_id) begin
          held_ids[pos] = held_ids[pos-1];
          pos--;
        end
        held_ids[pos] = offer.group_id;
        held++;
        outcome = sus_pkg::STATUS_INSERTED;
        inserted++;
      end
      w.kind = sus_pkg::KIND_STATUS;
      w.status = outcome;
      w.value = offer.group_id;
      w.entry_count = sus_pkg::CNT_W'(held);
      w.last_out = !offer.last || held == 0;
      owed_words.push_back(w);
      if (offer.last) begin
        for (int i = 0; i < held; i++) begin
          w.kind = sus_pkg::KIND_ENTRY;
          w.status = sus_pkg::STATUS_INSERTED;
          w.value = held_ids[i];
          w.entry_count = sus_pkg::CNT_W'(held);
          w.last_out = (i + 1 == held);
          owed_words.push_back(w);
        end
      end
    endfunction

    function void check_word(input sus_pkg::sus_out_t got);
      sus_pkg::sus_out_t want;
      words_checked++;
      if (owed_words.size() == 0) begin
        $error("unexpected word: kind %0d status %0d value %0h count %0d last_out %0d",
               got.kind, got.status, got.value, got.entry_count, got.last_out);
        errors++;
        return;
      end
      want = owed_words.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("value: expected %0h, actual %0h", want.value, got.value);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d",
               want.entry_count, got.entry_count);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0d, actual %0d", want.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  sus_pkg::sus_in_t          in_data;
  logic                      out_valid;
  logic                      out_ready;
  sus_pkg::sus_out_t         out_data;
  logic                      cfg_we;
  logic [sus_pkg::CNT_W-1:0] cfg_wdata;

  id_set_scoreboard sb = new();
  bit               quiet = 0;
  bit               hold_request = 0;
  int               offers_sent = 0;

  sorted_unique_id_set_merge #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("tb_sorted_unique_id_set_merge: FAIL");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_ready = 1'b0;
        repeat (200) @(negedge clk);
      end else begin
        out_ready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 20);
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_word(out_data);
  end

  task automatic send_offer(input logic [sus_pkg::ID_W-1:0] gid, input logic f,
                            input logic l);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.group_id = gid;
    in_data.first = f;
    in_data.last = l;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_offer(in_data);
    offers_sent++;
  endtask

  // The limit is only changed once every owed word has come out.
  task automatic set_capacity(input logic [sus_pkg::CNT_W-1:0] limit);
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wdata = limit;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_capacity(limit);
  endtask

  // Mostly well-formed sets opened by first and closed by last, some noise.
  task automatic run_phase(input int target);
    int                       done;
    int                       size;
    int                       base;
    bit                       broken;
    bit                       narrow;
    logic [sus_pkg::ID_W-1:0] gid;
    done = 0;
    while (done < target) begin
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      broken = ($urandom_range(0, 4) == 0);
      narrow = 1'($urandom_range(0, 1));
      base = $urandom_range(0, 65535 - 15);
      for (int k = 0; k < size; k++) begin
        case ($urandom_range(0, 19))
          0: gid = '0;
          1: gid = '1;
          default: gid = narrow ? sus_pkg::ID_W'(base + $urandom_range(0, 15))
                                : sus_pkg::ID_W'($urandom_range(0, 65535));
        endcase
        if (broken) begin
          send_offer(gid, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          send_offer(gid, k == 0, k == size - 1);
        end
      end
      done += size;
    end
  endtask

  task automatic fill_set(input int n);
    for (int k = 0; k < n; k++) begin
      send_offer(sus_pkg::ID_W'($urandom_range(0, 65535)), k == 0, k == n - 1);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Extremes, middle insert and duplicates at full capacity.
    set_capacity(sus_pkg::CNT_W'(32));
    send_offer(16'h0000, 1'b1, 1'b0);
    send_offer(16'hFFFF, 1'b0, 1'b0);
    send_offer(16'h8000, 1'b0, 1'b0);
    send_offer(16'h0000, 1'b0, 1'b0);
    send_offer(16'hFFFF, 1'b0, 1'b1);
    send_offer(16'd5, 1'b1, 1'b1);
    send_offer(16'd30, 1'b0, 1'b0);
    send_offer(16'd10, 1'b0, 1'b0);
    send_offer(16'd20, 1'b0, 1'b0);
    // Limit written below the held count: held IDs stay, new ones drop.
    set_capacity(sus_pkg::CNT_W'(2));
    send_offer(16'd40, 1'b0, 1'b0);
    send_offer(16'd20, 1'b0, 1'b0);
    send_offer(16'd40, 1'b0, 1'b1);
    // Zero capacity, including last on an empty set.
    set_capacity(sus_pkg::CNT_W'(0));
    send_offer(16'd7, 1'b1, 1'b1);
    send_offer(16'd7, 1'b0, 1'b0);
    set_capacity(sus_pkg::CNT_W'(1));
    send_offer(16'd9, 1'b1, 1'b0);
    send_offer(16'd3, 1'b0, 1'b0);
    send_offer(16'd9, 1'b0, 1'b1);
    // A limit above the table depth saturates.
    set_capacity(sus_pkg::CNT_W'(63));
    send_offer(16'd100, 1'b1, 1'b0);
    send_offer(16'd50, 1'b0, 1'b1);

    set_capacity(sus_pkg::CNT_W'(32));
    hold_request = 1;
    run_phase(50);
    set_capacity(sus_pkg::CNT_W'(1));
    run_phase(40);
    set_capacity(sus_pkg::CNT_W'(63));
    fill_set(40);
    run_phase(30);
    set_capacity(sus_pkg::CNT_W'(0));
    run_phase(30);
    quiet = 1;
    set_capacity(sus_pkg::CNT_W'(5));
    run_phase(60);
    quiet = 0;
    set_capacity(sus_pkg::CNT_W'(20));
    fill_set(25);
    run_phase(40);

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Run covered %0d offered IDs and %0d result words at limits %s.",
             offers_sent, sb.words_checked, "32, 2, 0, 1, 63, 5, 20");
    $display("Outcomes: %0d inserted, %0d duplicates, %0d dropped.",
             sb.inserted, sb.duplicates, sb.dropped);
    if (sb.errors == 0) begin
      $display("tb_sorted_unique_id_set_merge: PASS");
    end else begin
      $display("tb_sorted_unique_id_set_merge: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
